FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file tvna_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while rstn is low.
`define TVNA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define TVNA_ASSERT_IMP(name, clk, rstn, cond, prop, msg) \
  `TVNA_ASSERT(name, clk, rstn, (cond) |-> (prop), msg)

// Next-cycle form: when cond holds, prop must hold in the next cycle.
`define TVNA_ASSERT_NXT(name, clk, rstn, cond, prop, msg) \
  `TVNA_ASSERT(name, clk, rstn, (cond) |=> (prop), msg)

`endif

FILE: rtl/tvna_pkg.sv
// Package for the three-voice note allocator: sizes, codes, cell structs
// and the velocity-to-attenuation function. No dependencies.
package tvna_pkg;

  localparam int unsigned VOICES     = 3;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CNT_W      = $clog2(VOICES + 1);

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned VOICE_W = 2;
  localparam int unsigned ATT_W   = 4;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned ACT_W   = 2;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [ATT_W-1:0]      ATT_SILENT = 4'hf;
  localparam logic [MASK_W-1:0]     MASK_RESET = 3'd7;
  localparam logic [ACT_W-1:0]      ACT_MAX    = 2'd3;

  // ceil(2^20 / 254): exact floor division for dividends below 4096.
  localparam logic [12:0] ATT_RECIP = 13'd4129;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_ASSIGN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Running search result handed from cell to cell.
  typedef struct packed {
    logic                  match_v;
    logic [VIDX_W-1:0]     match_idx;
    logic                  free_v;
    logic [VIDX_W-1:0]     free_idx;
    logic                  old_v;
    logic [VIDX_W-1:0]     old_idx;
    logic [STAMP_BITS-1:0] old_stamp;
  } scan_t;

  localparam scan_t SCAN_INIT = '0;

  // Update broadcast to all cells in the commit cycle.
  typedef struct packed {
    op_e                   op;
    logic [VIDX_W-1:0]     pick;
    logic [STAMP_BITS-1:0] stamp;
  } commit_t;

  typedef struct packed {
    logic active;
    logic freed;
  } cell_status_t;

  // 15 - round(vel * 15 / 127), i.e. 15 - floor((30*vel + 127) / 254).
  function automatic logic [ATT_W-1:0] atten_of(input logic [VEL_W-1:0] vel);
    logic [11:0] x;
    logic [24:0] p;
    x = 12'(vel) * 12'd30 + 12'd127;
    p = 25'(x) * 25'(ATT_RECIP);
    return ATT_SILENT - p[23:20];
  endfunction

endpackage

FILE: rtl/tvna_if.sv
// Valid/ready channel interfaces for the note allocator.
// Depends on tvna_pkg.
interface tvna_in_if;
  logic                        valid;
  logic                        ready;
  logic [tvna_pkg::CMD_W-1:0]  cmd;
  logic [tvna_pkg::NOTE_W-1:0] note;
  logic [tvna_pkg::VEL_W-1:0]  velocity;

  modport source (output valid, cmd, note, velocity, input ready);
  modport sink   (input valid, cmd, note, velocity, output ready);
endinterface

interface tvna_out_if;
  logic                         valid;
  logic                         ready;
  logic                         assigned_valid;
  logic [tvna_pkg::VOICE_W-1:0] voice;
  logic                         stolen;
  logic [tvna_pkg::ATT_W-1:0]   voice_attenuation;
  logic [tvna_pkg::MASK_W-1:0]  freed_mask;
  logic [tvna_pkg::ACT_W-1:0]   active_count;
  logic                         any_active;

  modport source (output valid, assigned_valid, voice, stolen, voice_attenuation,
                  freed_mask, active_count, any_active, input ready);
  modport sink   (input valid, assigned_valid, voice, stolen, voice_attenuation,
                  freed_mask, active_count, any_active, output ready);
endinterface

FILE: rtl/tvna_cell.sv
// One voice cell: holds busy/note/stamp, adds itself to the passing search
// record, and applies the commit broadcast. Depends on tvna_pkg.
module tvna_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tvna_pkg::VIDX_W-1:0]   idx_i,
  input  logic                          en_i,
  input  logic [tvna_pkg::NOTE_W-1:0]   note_i,
  input  tvna_pkg::scan_t               scan_i,
  output tvna_pkg::scan_t               scan_o,
  input  tvna_pkg::commit_t             cmt_i,
  output tvna_pkg::cell_status_t        status_o
);
  import tvna_pkg::*;

  logic                  busy_q, busy_d;
  logic [NOTE_W-1:0]     note_q, note_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  scan_t                 scan_q, scan_d;
  logic                  note_hit;
  logic                  freed;

  assign note_hit = busy_q && (note_q == note_i);

  // search step
  always_comb begin
    scan_d = scan_i;
    if (en_i && note_hit && !scan_i.match_v) begin
      scan_d.match_v   = 1'b1;
      scan_d.match_idx = idx_i;
    end
    if (en_i && !busy_q && !scan_i.free_v) begin
      scan_d.free_v   = 1'b1;
      scan_d.free_idx = idx_i;
    end
    // strict less: equal stamps keep the lower index seen earlier
    if (en_i && (!scan_i.old_v || (stamp_q < scan_i.old_stamp))) begin
      scan_d.old_v     = 1'b1;
      scan_d.old_idx   = idx_i;
      scan_d.old_stamp = stamp_q;
    end
  end

  // commit
  always_comb begin
    busy_d  = busy_q;
    note_d  = note_q;
    stamp_d = stamp_q;
    freed   = 1'b0;
    unique case (cmt_i.op)
      OP_ASSIGN: begin
        if (cmt_i.pick == idx_i) begin
          busy_d  = 1'b1;
          note_d  = note_i;
          stamp_d = cmt_i.stamp;
        end
      end
      OP_RELEASE: begin
        if (note_hit) begin
          busy_d  = 1'b0;
          note_d  = '0;
          stamp_d = '0;
          freed   = 1'b1;
        end
      end
      OP_CLEAR: begin
        busy_d  = 1'b0;
        note_d  = '0;
        stamp_d = '0;
        freed   = busy_q;
      end
      default: ;
    endcase
  end

  assign status_o = '{active: en_i && busy_q, freed: freed};
  assign scan_o   = scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      note_q  <= '0;
      stamp_q <= '0;
      scan_q  <= SCAN_INIT;
    end else begin
      busy_q  <= busy_d;
      note_q  <= note_d;
      stamp_q <= stamp_d;
      scan_q  <= scan_d;
    end
  end

endmodule

FILE: rtl/three_voice_note_allocator_unit.sv
// Three-voice note allocator, top level: control sequencer, stamp counter,
// result register and the chain of voice cells. Depends on tvna_pkg,
// tvna_if and tvna_cell.
//
// Usage:
//   in_ch  (sink)   : one note event per item: cmd, note, velocity.
//   out_ch (source) : exactly one result item per accepted event.
//   cfg_we_i/cfg_wdata_i : writes voice_enable_mask; write only while idle.
// Timing:
//   An accepted item runs a search record through the voice cells, one cell
//   per cycle, then a commit state updates the chosen cells and a load state
//   counts active voices and loads the result. One item is in flight at a
//   time: the next item is taken only once the result has been loaded.
// Stall:
//   The result register holds its item until out_ch.ready. While it is full
//   the next item is still accepted and searched; it waits before loading.
// Reset:
//   All voices free, notes and stamps zero, stamp counter zero, enable mask
//   7, no result pending, in_ch ready once reset is released.
module three_voice_note_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tvna_in_if.sink                   in_ch,
  tvna_out_if.source                out_ch,
  input  logic                      cfg_we_i,
  input  logic [tvna_pkg::MASK_W-1:0] cfg_wdata_i
);
  import tvna_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_LOAD   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [MASK_W-1:0]     mask_q;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d, stamp_next;
  logic [VIDX_W-1:0]     cnt_q, cnt_d;

  // accepted event
  logic [CMD_W-1:0]  cmd_q;
  logic [NOTE_W-1:0] note_q;
  logic [ATT_W-1:0]  att_q;

  // result held between commit and load
  logic              pend_asg_q, pend_asg_d;
  logic [VIDX_W-1:0] pend_voice_q, pend_voice_d;
  logic              pend_stolen_q, pend_stolen_d;
  logic [MASK_W-1:0] pend_freed_q, pend_freed_d;

  // output register
  logic              out_valid_q;
  logic              out_asg_q;
  logic [VOICE_W-1:0] out_voice_q;
  logic              out_stolen_q;
  logic [ATT_W-1:0]  out_att_q;
  logic [MASK_W-1:0] out_freed_q;
  logic [ACT_W-1:0]  out_act_q;

  scan_t        scan_w [VOICES+1];
  commit_t      cmt;
  cell_status_t status_w [VOICES];
  scan_t        fin;

  logic              in_acc;
  logic              load;
  logic [MASK_W-1:0] freed_now;
  logic [CNT_W-1:0]  act_sum;
  logic [ACT_W-1:0]  act_sat;

  // ---------------------------------------------------------------- cells
  assign scan_w[0] = SCAN_INIT;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    logic en;
    if (g < MASK_W) begin : g_en
      assign en = mask_q[g];
    end else begin : g_dis
      assign en = 1'b0;   // voices past the mask are never enabled
    end

    tvna_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (VIDX_W'(g)),
      .en_i     (en),
      .note_i   (note_q),
      .scan_i   (scan_w[g]),
      .scan_o   (scan_w[g+1]),
      .cmt_i    (cmt),
      .status_o (status_w[g])
    );
  end

  assign fin = scan_w[VOICES];

  // ----------------------------------------------------------- handshakes
  // no item is taken while reset is held
  assign in_ch.ready = rst_ni && (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load        = (state_q == ST_LOAD) && (!out_valid_q || out_ch.ready);

  assign stamp_next = (stamp_q == STAMP_MAX) ? stamp_q : stamp_q + 1'b1;

  // ------------------------------------------------------ commit decision
  always_comb begin
    cmt.op        = OP_NONE;
    cmt.pick      = '0;
    cmt.stamp     = stamp_next;
    pend_asg_d    = pend_asg_q;
    pend_voice_d  = pend_voice_q;
    pend_stolen_d = pend_stolen_q;
    pend_freed_d  = pend_freed_q;
    stamp_d       = stamp_q;

    if (state_q == ST_COMMIT) begin
      pend_asg_d    = 1'b0;
      pend_voice_d  = '0;
      pend_stolen_d = 1'b0;
      if (cmd_q == CMD_NOTE_ON) begin
        // same note, then free voice, then steal the oldest
        priority if (fin.match_v) begin
          cmt.op   = OP_ASSIGN;
          cmt.pick = fin.match_idx;
        end else if (fin.free_v) begin
          cmt.op   = OP_ASSIGN;
          cmt.pick = fin.free_idx;
        end else if (fin.old_v) begin
          cmt.op        = OP_ASSIGN;
          cmt.pick      = fin.old_idx;
          pend_stolen_d = 1'b1;
        end else begin
          cmt.op = OP_NONE;   // no enabled voice: counter holds
        end
        if (cmt.op == OP_ASSIGN) begin
          pend_asg_d   = 1'b1;
          pend_voice_d = cmt.pick;
          stamp_d      = stamp_next;
        end
      end else if (cmd_q == CMD_NOTE_OFF) begin
        cmt.op = OP_RELEASE;
      end else if (cmd_q == CMD_CLEAR) begin
        cmt.op  = OP_CLEAR;
        stamp_d = '0;
      end
      pend_freed_d = freed_now;
    end
  end

  always_comb begin
    freed_now = '0;
    for (int unsigned v = 0; v < VOICES; v++) begin
      if (v < MASK_W) begin
        freed_now[v] = status_w[v].freed;
      end
    end
  end

  always_comb begin
    act_sum = '0;
    for (int unsigned v = 0; v < VOICES; v++) begin
      act_sum = act_sum + CNT_W'(status_w[v].active);
    end
  end

  assign act_sat = (act_sum > CNT_W'(ACT_MAX)) ? ACT_MAX : ACT_W'(act_sum);

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == VIDX_W'(VOICES - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mask_q      <= MASK_RESET;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stamp_q <= stamp_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_ch.cmd;
      note_q <= in_ch.note;
      att_q  <= atten_of(in_ch.velocity);
    end
    pend_asg_q    <= pend_asg_d;
    pend_voice_q  <= pend_voice_d;
    pend_stolen_q <= pend_stolen_d;
    pend_freed_q  <= pend_freed_d;
    if (load) begin
      out_asg_q    <= pend_asg_q;
      out_voice_q  <= VOICE_W'(pend_voice_q);
      out_stolen_q <= pend_stolen_q;
      out_att_q    <= pend_asg_q ? att_q : ATT_SILENT;
      out_freed_q  <= pend_freed_q;
      out_act_q    <= act_sat;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.assigned_valid    = out_asg_q;
  assign out_ch.voice             = out_voice_q;
  assign out_ch.stolen            = out_stolen_q;
  assign out_ch.voice_attenuation = out_att_q;
  assign out_ch.freed_mask        = out_freed_q;
  assign out_ch.active_count      = out_act_q;
  assign out_ch.any_active        = (out_act_q != '0);

endmodule

FILE: rtl/tvna_checker.sv
// Port-level checks for the note allocator, bound to the top level.
// Depends on tvna_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvna_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          assigned_valid_i,
  input logic [tvna_pkg::VOICE_W-1:0]  voice_i,
  input logic                          stolen_i,
  input logic [tvna_pkg::ATT_W-1:0]    voice_attenuation_i,
  input logic [tvna_pkg::MASK_W-1:0]   freed_mask_i,
  input logic [tvna_pkg::ACT_W-1:0]    active_count_i,
  input logic                          any_active_i
);
  import tvna_pkg::*;

  // result stays up until taken
  `TVNA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i,
                   "result dropped while stalled")

  // one item in flight: ready drops right after an accept
  `TVNA_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i,
                   "item accepted while busy")

  `TVNA_ASSERT_IMP(a_any_active, clk_i, rst_ni, out_valid_i,
                   any_active_i == (active_count_i != '0),
                   "any_active disagrees with count")

  `TVNA_ASSERT_IMP(a_unassigned, clk_i, rst_ni, out_valid_i && !assigned_valid_i,
                   (voice_i == '0) && !stolen_i && (voice_attenuation_i == ATT_SILENT),
                   "unassigned result not idle")

  `TVNA_ASSERT_IMP(a_freed_excl, clk_i, rst_ni, out_valid_i && (freed_mask_i != '0),
                   !assigned_valid_i && (active_count_i != ACT_MAX),
                   "release result also assigns")

endmodule

bind three_voice_note_allocator_unit tvna_checker u_tvna_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_ch.valid),
  .in_ready_i          (in_ch.ready),
  .out_valid_i         (out_ch.valid),
  .out_ready_i         (out_ch.ready),
  .assigned_valid_i    (out_ch.assigned_valid),
  .voice_i             (out_ch.voice),
  .stolen_i            (out_ch.stolen),
  .voice_attenuation_i (out_ch.voice_attenuation),
  .freed_mask_i        (out_ch.freed_mask),
  .active_count_i      (out_ch.active_count),
  .any_active_i        (out_ch.any_active)
);

FILE: bench/testbench.sv
// Self-checking bench for three_voice_note_allocator_unit: directed table, then random phases.
// Depends on tvna_pkg, tvna_in_if / tvna_out_if and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tvna_pkg::*;

  // cmd value 3 has no package name; the block must leave state alone on it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Receiver hold-off length and items per random phase.
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 430;

  // One result item, field for field as on out_ch.
  typedef struct packed {
    logic               assigned;
    logic [VOICE_W-1:0] voice;
    logic               stolen;
    logic [ATT_W-1:0]   atten;
    logic [MASK_W-1:0]  freed;
    logic [ACT_W-1:0]   active;
    logic               any_active;
  } alloc_result_t;

  // One directed row: mask in force, the event, and an optional typed-in result.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [CMD_W-1:0]  cmd;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              typed;
    alloc_result_t     res;
  } note_row_t;

  localparam alloc_result_t NO_RES   = '0;
  // Nothing assigned, nothing freed, nothing active.
  localparam alloc_result_t IDLE_RES = '{1'b0, 2'd0, 1'b0, 4'hf, 3'd0, 2'd0, 1'b0};

  localparam int NROWS = 23;
  localparam note_row_t DIRECTED_ROWS [NROWS] = '{
    // note-off right after reset: voices hold note 0 but are free
    '{3'd7, CMD_NOTE_OFF, 7'd0,   7'd0,   1'b1, IDLE_RES},
    // full velocity, top note: first free voice, loudest
    '{3'd7, CMD_NOTE_ON,  7'd127, 7'd127, 1'b1, '{1'b1, 2'd0, 1'b0, 4'h0, 3'd0, 2'd1, 1'b1}},
    // zero velocity still takes a voice, silent
    '{3'd7, CMD_NOTE_ON,  7'd0,   7'd0,   1'b1, '{1'b1, 2'd1, 1'b0, 4'hf, 3'd0, 2'd2, 1'b1}},
    '{3'd7, CMD_NOTE_ON,  7'd64,  7'd64,  1'b0, NO_RES},
    // retrigger of a held note
    '{3'd7, CMD_NOTE_ON,  7'd127, 7'd1,   1'b0, NO_RES},
    // all busy: oldest stamp is stolen
    '{3'd7, CMD_NOTE_ON,  7'd30,  7'd100, 1'b0, NO_RES},
    '{3'd7, CMD_NOTE_OFF, 7'd64,  7'd0,   1'b0, NO_RES},
    '{3'd7, CMD_UNUSED,   7'd5,   7'd127, 1'b0, NO_RES},
    '{3'd7, CMD_CLEAR,    7'd0,   7'd0,   1'b0, NO_RES},
    // clear on an empty set
    '{3'd7, CMD_CLEAR,    7'd127, 7'd127, 1'b1, IDLE_RES},
    // no voice enabled at all
    '{3'd0, CMD_NOTE_ON,  7'd10,  7'd127, 1'b1, IDLE_RES},
    '{3'd0, CMD_NOTE_OFF, 7'd10,  7'd0,   1'b1, IDLE_RES},
    // only voice 1 enabled
    '{3'd2, CMD_NOTE_ON,  7'd20,  7'd127, 1'b1, '{1'b1, 2'd1, 1'b0, 4'h0, 3'd0, 2'd1, 1'b1}},
    '{3'd2, CMD_NOTE_ON,  7'd21,  7'd50,  1'b0, NO_RES},
    '{3'd1, CMD_NOTE_ON,  7'd22,  7'd90,  1'b0, NO_RES},
    // note-off frees a disabled voice too
    '{3'd1, CMD_NOTE_OFF, 7'd21,  7'd0,   1'b0, NO_RES},
    // voice 0 holds 22 but is disabled: no match there
    '{3'd4, CMD_NOTE_ON,  7'd22,  7'd127, 1'b0, NO_RES},
    // two voices hold 22: lowest enabled one matches
    '{3'd7, CMD_NOTE_ON,  7'd22,  7'd8,   1'b0, NO_RES},
    '{3'd7, CMD_NOTE_ON,  7'd99,  7'd127, 1'b0, NO_RES},
    '{3'd7, CMD_NOTE_ON,  7'd98,  7'd0,   1'b0, NO_RES},
    '{3'd7, CMD_NOTE_OFF, 7'd22,  7'd0,   1'b0, NO_RES},
    '{3'd7, CMD_UNUSED,   7'd127, 7'd0,   1'b0, NO_RES},
    // clear with voice 0 disabled: busy voices 1 and 2 are reported freed
    '{3'd6, CMD_CLEAR,    7'd0,   7'd0,   1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  tvna_in_if  in_ch ();
  tvna_out_if out_ch ();

  three_voice_note_allocator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Voice model: own copy of the allocator state.
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0]     enable_mask;
  logic                  busy      [VOICES];
  logic [NOTE_W-1:0]     held_note [VOICES];
  logic [STAMP_BITS-1:0] age       [VOICES];
  logic [STAMP_BITS-1:0] stamp_now;

  alloc_result_t pending_results [$];   // expected result items, oldest first
  int            mismatch_count;

  // Idle chances in percent, set per phase by the stimulus process.
  int tx_idle_pct;
  int rx_idle_pct;
  // Bumped by stimulus to ask the receiver for a long hold-off.
  int hold_req;
  int hold_seen;
  int hold_left;

  always #2 clk = ~clk;

  function automatic void release_voice(int v);
    busy[v]      = 1'b0;
    held_note[v] = '0;
    age[v]       = '0;
  endfunction

  // Works out the result of one event and advances the voice model.
  function automatic alloc_result_t allocate_note_event(logic [CMD_W-1:0] cmd,
                                                        logic [NOTE_W-1:0] note,
                                                        logic [VEL_W-1:0] vel);
    alloc_result_t r;
    int pick;
    int n;
    logic [11:0] scaled;
    r = '0;
    r.atten = ATT_SILENT;
    pick = -1;
    n = 0;
    case (cmd)
      CMD_NOTE_ON: begin
        // held note first, then a free voice, then the oldest stamp
        for (int v = 0; v < VOICES; v++)
          if (pick < 0 && enable_mask[v] && busy[v] && held_note[v] == note) pick = v;
        for (int v = 0; v < VOICES; v++)
          if (pick < 0 && enable_mask[v] && !busy[v]) pick = v;
        if (pick < 0) begin
          for (int v = 0; v < VOICES; v++)
            if (enable_mask[v] && (pick < 0 || age[v] < age[pick])) pick = v;
          r.stolen = (pick >= 0);
        end
        if (pick >= 0) begin
          if (stamp_now != STAMP_MAX) stamp_now++;
          // round half up of vel*15/127
          scaled = 12'(vel) * 12'd30 + 12'd127;
          r.atten = 4'd15 - 4'(scaled / 12'd254);
          busy[pick]      = 1'b1;
          held_note[pick] = note;
          age[pick]       = stamp_now;
          r.assigned      = 1'b1;
          r.voice         = VOICE_W'(pick);
        end
      end
      CMD_NOTE_OFF: begin
        // enabled or not, every holder of the note goes
        for (int v = 0; v < VOICES; v++)
          if (busy[v] && held_note[v] == note) begin
            release_voice(v);
            r.freed[v] = 1'b1;
          end
      end
      CMD_CLEAR: begin
        for (int v = 0; v < VOICES; v++) begin
          r.freed[v] = busy[v];
          release_voice(v);
        end
        stamp_now = '0;
      end
      default: ;
    endcase
    for (int v = 0; v < VOICES; v++)
      if (enable_mask[v] && busy[v]) n++;
    r.active     = ACT_W'(n);
    r.any_active = (n > 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result item is held against the oldest expectation.
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("assigned_valid",    want.assigned,   out_ch.assigned_valid);
        check_field("voice",             want.voice,      out_ch.voice);
        check_field("stolen",            want.stolen,     out_ch.stolen);
        check_field("voice_attenuation", want.atten,      out_ch.voice_attenuation);
        check_field("freed_mask",        want.freed,      out_ch.freed_mask);
        check_field("active_count",      want.active,     out_ch.active_count);
        check_field("any_active",        want.any_active, out_ch.any_active);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Event side.
  // ---------------------------------------------------------------------------

  // Offers one event, waits for the handshake, then books the expectation.
  // valid stays high on exit so back-to-back items need no second assignment.
  task automatic send_event(logic [CMD_W-1:0] c, logic [NOTE_W-1:0] n,
                            logic [VEL_W-1:0] v, logic typed, alloc_result_t typed_res);
    alloc_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid    <= 1'b0;
      in_ch.cmd      <= CMD_W'($urandom);
      in_ch.note     <= NOTE_W'($urandom);
      in_ch.velocity <= VEL_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.note     <= n;
    in_ch.velocity <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = allocate_note_event(c, n, v);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
  endtask

  // Stops offering and waits until every booked result has come back,
  // then lets the pipeline settle before any register write.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_voice_mask(logic [MASK_W-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    enable_mask = m;
  endtask

  initial begin
    logic [NOTE_W-1:0] pool [5];
    logic [MASK_W-1:0] seg_mask;
    logic [CMD_W-1:0]  c;
    logic [NOTE_W-1:0] n;
    int sent;
    int seg;
    int seg_len;
    int roll;

    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = '0;
    in_ch.note     = '0;
    in_ch.velocity = '0;
    out_ch.ready   = 1'b0;
    mismatch_count = 0;
    hold_req       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    tx_idle_pct    = 17;
    rx_idle_pct    = 87;

    // model reset: all free, mask at its reset value
    enable_mask = MASK_RESET;
    for (int v = 0; v < VOICES; v++) release_voice(v);
    stamp_now = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. A row with a new mask first lets the block go idle.
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].mask != enable_mask) begin
        drain_results();
        write_voice_mask(DIRECTED_ROWS[i].mask);
      end
      send_event(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].note, DIRECTED_ROWS[i].vel,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end
    drain_results();

    // Random phases: slow receiver, then slow sender, then full speed.
    // Each phase is cut into segments with their own mask and note pool,
    // so held notes repeat and retrigger, note-off and steal paths get hit.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 17 : 0;
      sent = 0;
      seg  = 0;
      while (sent < PHASE_ITEMS) begin
        drain_results();
        // reset value and all-off come up in every phase, the rest at random
        if (seg == 0)      seg_mask = MASK_RESET;
        else if (seg == 1) seg_mask = 3'd0;
        else if ($urandom_range(1) == 0) seg_mask = 3'd7;
        else               seg_mask = MASK_W'($urandom_range(7));
        write_voice_mask(seg_mask);
        for (int i = 0; i < 5; i++) pool[i] = NOTE_W'($urandom);
        seg_len = (seg_mask == 3'd0) ? 10 : $urandom_range(60, 20);
        // long receiver stall while the sender keeps offering items
        if (seg == 2 && phase != 1) hold_req++;
        for (int k = 0; k < seg_len; k++) begin
          roll = $urandom_range(99);
          if (roll < 58)      c = CMD_NOTE_ON;
          else if (roll < 90) c = CMD_NOTE_OFF;
          else if (roll < 96) c = CMD_CLEAR;
          else                c = CMD_UNUSED;
          n = ($urandom_range(9) == 0) ? NOTE_W'($urandom) : pool[$urandom_range(4)];
          send_event(c, n, VEL_W'($urandom), 1'b0, NO_RES);
          sent++;
        end
        seg++;
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tvna_pkg.sv
rtl/tvna_if.sv
rtl/tvna_cell.sv
rtl/three_voice_note_allocator_unit.sv
rtl/tvna_checker.sv
bench/testbench.sv
